// ===== rtl/complex_arith_unit_macros.svh =====
// ----------------------------------------------------------------------------
// complex_arith_unit_macros.svh
// Assertion helpers used by the output stage of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// property that holds at every clock edge
`define CAU_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent this cycle implies consequent in the next cycle
`define CAU_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Types, operation codes, constants and helper functions of the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;
	localparam logic [2:0] OP_ARG = 3'd5;

	localparam int DIV_STEPS  = 80;
	localparam int SQRT_STEPS = 32;
	localparam int ARG_STEPS  = 24;

	localparam logic signed [31:0] PI_Z      = 32'sd52707179;
	localparam logic signed [31:0] HALF_PI_Z = 32'sd26353589;
	localparam logic [41:0]        Q_CAP     = 42'd1 << 40;
	localparam logic [63:0]        DEN_EPS   = 64'd4;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} cau_in_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               div_error;
		logic               overflow;
	} cau_out_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic               derr;
		logic               neg_re;
		logic               neg_im;
		logic [63:0]        n_re;
		logic [63:0]        n_im;
		logic [63:0]        r_re;
		logic [63:0]        r_im;
		logic [40:0]        q_re;
		logic [40:0]        q_im;
		logic [63:0]        den;
		logic [63:0]        sq_n;
		logic [63:0]        sq_res;
		logic signed [35:0] cx;
		logic signed [35:0] cy;
		logic signed [31:0] cz;
		logic               a_zero;
		logic [31:0]        as_re;
		logic [31:0]        as_im;
		logic               as_ovf;
	} cau_lane_t;

	// saturate a sign and magnitude to q16.16, msb of result is overflow
	function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] m);
		logic [63:0] neg_m;
		neg_m = ~m + 64'd1;
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000) sat_sm = {1'b1, 32'h8000_0000};
			else sat_sm = {1'b0, neg_m[31:0]};
		end else if (m > 64'h0000_0000_7FFF_FFFF) begin
			sat_sm = {1'b1, 32'h7FFF_FFFF};
		end else begin
			sat_sm = {1'b0, m[31:0]};
		end
	endfunction

	// arctangent of 2^-i in units of 2^-24 rad
	function automatic logic signed [31:0] atan_z(input logic [4:0] i);
		case (i)
			5'd0:    atan_z = 32'sd13176795;
			5'd1:    atan_z = 32'sd7778716;
			5'd2:    atan_z = 32'sd4110060;
			5'd3:    atan_z = 32'sd2086331;
			5'd4:    atan_z = 32'sd1047214;
			5'd5:    atan_z = 32'sd524117;
			5'd6:    atan_z = 32'sd262123;
			5'd7:    atan_z = 32'sd131069;
			5'd8:    atan_z = 32'sd65536;
			5'd9:    atan_z = 32'sd32768;
			5'd10:   atan_z = 32'sd16384;
			5'd11:   atan_z = 32'sd8192;
			5'd12:   atan_z = 32'sd4096;
			5'd13:   atan_z = 32'sd2048;
			5'd14:   atan_z = 32'sd1024;
			5'd15:   atan_z = 32'sd512;
			5'd16:   atan_z = 32'sd256;
			5'd17:   atan_z = 32'sd128;
			5'd18:   atan_z = 32'sd64;
			5'd19:   atan_z = 32'sd32;
			5'd20:   atan_z = 32'sd16;
			5'd21:   atan_z = 32'sd8;
			5'd22:   atan_z = 32'sd4;
			5'd23:   atan_z = 32'sd2;
			default: atan_z = 32'sd0;
		endcase
	endfunction

endpackage

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Operand stages: products, sums and denominator, add and subtract results,
// angle operand normalization and quadrant rotation.
// ----------------------------------------------------------------------------
module cau_front
	import cau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      op_valid,
	input  cau_in_t   op,
	output logic      lane_valid,
	output cau_lane_t lane
);

	function automatic logic [32:0] sat_s33(input logic signed [32:0] s);
		if (s > 33'sd2147483647) sat_s33 = {1'b1, 32'h7FFF_FFFF};
		else if (s < -33'sd2147483648) sat_s33 = {1'b1, 32'h8000_0000};
		else sat_s33 = {1'b0, s[31:0]};
	endfunction

	logic signed [31:0] ar, ai, br, bi, sel_re, sel_im;
	logic signed [32:0] are, aie, bre, bie, sum_re33, sum_im33;
	logic [32:0]        sat_re, sat_im;
	logic signed [63:0] p0_c, p1_c, p2_c, p3_c;
	logic [63:0]        bb0_c, bb1_c;
	logic [31:0]        mx, my, big, nb;
	logic [4:0]         sh;
	logic signed [32:0] xn, yn;

	logic               valid_s1;
	logic [2:0]         kind_s1;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic [63:0]        bb0_s1, bb1_s1;
	logic [31:0]        as_re_s1, as_im_s1;
	logic               as_ovf_s1;
	logic signed [32:0] ax_s1, ay_s1;
	logic               az_s1;

	logic signed [64:0] sum_re, sum_im;
	logic [64:0]        mag_re, mag_im;
	logic [63:0]        den_c;
	logic signed [32:0] xr, yr;
	logic signed [31:0] zr;
	cau_lane_t          lane_c;

	logic               valid_s2;
	cau_lane_t          lane_s2;

	assign ar = op.a_re;
	assign ai = op.a_im;
	assign br = op.b_re;
	assign bi = op.b_im;
	assign are = {ar[31], ar};
	assign aie = {ai[31], ai};
	assign bre = {br[31], br};
	assign bie = {bi[31], bi};

	assign sel_re = (op.kind == OP_MOD) ? ar : br;
	assign sel_im = (op.kind == OP_MOD) ? ai : bi;
	assign p0_c = ar * sel_re;
	assign p1_c = ai * sel_im;
	assign p2_c = ar * bi;
	assign p3_c = ai * br;
	assign bb0_c = br * br;
	assign bb1_c = bi * bi;

	assign sum_re33 = (op.kind == OP_SUB) ? are - bre : are + bre;
	assign sum_im33 = (op.kind == OP_SUB) ? aie - bie : aie + bie;
	assign sat_re = sat_s33(sum_re33);
	assign sat_im = sat_s33(sum_im33);

	// bring a nonzero larger magnitude into [2^30, 2^31]
	always_comb begin
		mx = are[32] ? ~are[31:0] + 32'd1 : are[31:0];
		my = aie[32] ? ~aie[31:0] + 32'd1 : aie[31:0];
		big = (mx > my) ? mx : my;
		nb = big;
		sh = 5'd0;
		if (nb < 32'h0000_8000) begin
			nb = nb << 16;
			sh = sh + 5'd16;
		end
		if (nb < 32'h0080_0000) begin
			nb = nb << 8;
			sh = sh + 5'd8;
		end
		if (nb < 32'h0800_0000) begin
			nb = nb << 4;
			sh = sh + 5'd4;
		end
		if (nb < 32'h2000_0000) begin
			nb = nb << 2;
			sh = sh + 5'd2;
		end
		if (nb < 32'h4000_0000) begin
			sh = sh + 5'd1;
		end
		xn = are <<< sh;
		yn = aie <<< sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= op.kind;
			p0_s1     <= p0_c;
			p1_s1     <= p1_c;
			p2_s1     <= p2_c;
			p3_s1     <= p3_c;
			bb0_s1    <= bb0_c;
			bb1_s1    <= bb1_c;
			as_re_s1  <= sat_re[31:0];
			as_im_s1  <= sat_im[31:0];
			as_ovf_s1 <= sat_re[32] | sat_im[32];
			ax_s1     <= xn;
			ay_s1     <= yn;
			az_s1     <= (ar == 32'sd0) && (ai == 32'sd0);
		end
	end

	always_comb begin
		if (kind_s1 == OP_MUL) begin
			sum_re = 65'(p0_s1) - 65'(p1_s1);
			sum_im = 65'(p2_s1) + 65'(p3_s1);
		end else begin
			sum_re = 65'(p0_s1) + 65'(p1_s1);
			sum_im = 65'(p3_s1) - 65'(p2_s1);
		end
		mag_re = sum_re[64] ? -sum_re : sum_re;
		mag_im = sum_im[64] ? -sum_im : sum_im;
		den_c = bb0_s1 + bb1_s1;

		// quadrant rotation for a negative real part
		if (ax_s1[32]) begin
			if (!ay_s1[32]) begin
				xr = ay_s1;
				yr = -ax_s1;
				zr = HALF_PI_Z;
			end else begin
				xr = -ay_s1;
				yr = ax_s1;
				zr = -HALF_PI_Z;
			end
		end else begin
			xr = ax_s1;
			yr = ay_s1;
			zr = 32'sd0;
		end

		lane_c.kind   = kind_s1;
		lane_c.derr   = (kind_s1 == OP_DIV) && (den_c <= DEN_EPS);
		lane_c.neg_re = sum_re[64];
		lane_c.neg_im = sum_im[64];
		lane_c.n_re   = mag_re[63:0];
		lane_c.n_im   = mag_im[63:0];
		lane_c.r_re   = 64'd0;
		lane_c.r_im   = 64'd0;
		lane_c.q_re   = 41'd0;
		lane_c.q_im   = 41'd0;
		lane_c.den    = den_c;
		lane_c.sq_n   = mag_re[63:0];
		lane_c.sq_res = 64'd0;
		lane_c.cx     = 36'(xr);
		lane_c.cy     = 36'(yr);
		lane_c.cz     = zr;
		lane_c.a_zero = az_s1;
		lane_c.as_re  = as_re_s1;
		lane_c.as_im  = as_im_s1;
		lane_c.as_ovf = as_ovf_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s2 <= lane_c;
		end
	end

	assign lane_valid = valid_s2;
	assign lane       = lane_s2;

endmodule

// ===== rtl/cau_cell.sv =====
// ----------------------------------------------------------------------------
// cau_cell
// One step of the chain: a restoring division step on both parts, a square
// root step and a vectoring rotation step, each where the step index applies.
// ----------------------------------------------------------------------------
module cau_cell
	import cau_pkg::*;
#(
	parameter int STEP = 0
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  cau_lane_t in_lane,
	output logic      out_valid,
	output cau_lane_t out_lane
);

	function automatic logic [104:0] div_step(input logic [63:0] r, input logic [40:0] q,
			input logic b, input logic [63:0] d);
		logic [64:0] rr;
		logic [41:0] qq;
		rr = {r, b};
		qq = {q, 1'b0};
		if (rr >= {1'b0, d}) begin
			rr = rr - {1'b0, d};
			qq[0] = 1'b1;
		end
		if (qq > Q_CAP) qq = Q_CAP;
		div_step = {rr[63:0], qq[40:0]};
	endfunction

	logic [63:0]        sq_n_nx, sq_res_nx;
	logic signed [35:0] cx_nx, cy_nx;
	logic signed [31:0] cz_nx;
	cau_lane_t          nx;
	logic               valid_q;
	cau_lane_t          lane_q;

	if (STEP < SQRT_STEPS) begin : g_sq
		localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * STEP);
		logic [64:0] t;
		assign t = {1'b0, in_lane.sq_res} + {1'b0, SQ_BIT};
		always_comb begin
			sq_n_nx   = in_lane.sq_n;
			sq_res_nx = in_lane.sq_res;
			if (in_lane.kind == OP_MOD) begin
				if ({1'b0, in_lane.sq_n} >= t) begin
					sq_n_nx   = in_lane.sq_n - t[63:0];
					sq_res_nx = (in_lane.sq_res >> 1) + SQ_BIT;
				end else begin
					sq_res_nx = in_lane.sq_res >> 1;
				end
			end
		end
	end else begin : g_sq_idle
		assign sq_n_nx   = in_lane.sq_n;
		assign sq_res_nx = in_lane.sq_res;
	end

	if (STEP < ARG_STEPS) begin : g_rot
		localparam logic signed [31:0] ANG = atan_z(5'(STEP));
		logic signed [35:0] x0, y0, xs, ys;
		logic signed [31:0] z0;
		assign x0 = in_lane.cx;
		assign y0 = in_lane.cy;
		assign z0 = in_lane.cz;
		assign xs = x0 >>> STEP;
		assign ys = y0 >>> STEP;
		always_comb begin
			cx_nx = x0;
			cy_nx = y0;
			cz_nx = z0;
			if (in_lane.kind == OP_ARG) begin
				if (!y0[35]) begin
					cx_nx = x0 + ys;
					cy_nx = y0 - xs;
					cz_nx = z0 + ANG;
				end else begin
					cx_nx = x0 - ys;
					cy_nx = y0 + xs;
					cz_nx = z0 - ANG;
				end
			end
		end
	end else begin : g_rot_idle
		assign cx_nx = in_lane.cx;
		assign cy_nx = in_lane.cy;
		assign cz_nx = in_lane.cz;
	end

	always_comb begin
		nx = in_lane;
		if (in_lane.kind == OP_DIV) begin
			{nx.r_re, nx.q_re} = div_step(in_lane.r_re, in_lane.q_re, in_lane.n_re[63],
				in_lane.den);
			{nx.r_im, nx.q_im} = div_step(in_lane.r_im, in_lane.q_im, in_lane.n_im[63],
				in_lane.den);
			nx.n_re = in_lane.n_re << 1;
			nx.n_im = in_lane.n_im << 1;
		end
		nx.sq_n   = sq_n_nx;
		nx.sq_res = sq_res_nx;
		nx.cx     = cx_nx;
		nx.cy     = cy_nx;
		nx.cz     = cz_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nx;
		end
	end

	assign out_valid = valid_q;
	assign out_lane  = lane_q;

endmodule

// ===== rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Rounding, angle clamp, saturation and result selection, followed by a
// two-word output buffer that sets the pipeline advance.
// ----------------------------------------------------------------------------
`include "complex_arith_unit_macros.svh"

module cau_back
	import cau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      lane_valid,
	input  cau_lane_t lane,
	input  logic      res_stall,
	output logic      adv,
	output logic      res_valid,
	output cau_out_t  res
);

	typedef struct packed {
		logic [2:0]  kind;
		logic        derr;
		logic        neg_re;
		logic        neg_im;
		logic [63:0] m_re;
		logic [63:0] m_im;
		logic [31:0] dir_re;
		logic [31:0] dir_im;
		logic        dir_ovf;
	} cau_rnd_t;

	localparam logic [1:0] SKID_DEPTH = 2'd2;

	logic               half_re, half_im;
	logic signed [31:0] z0, zc;
	logic signed [32:0] zr, zsh;
	logic [31:0]        arg_c;
	cau_rnd_t           rnd_c;
	logic               rnd_valid_s1;
	cau_rnd_t           rnd_s1;
	logic [32:0]        sr, si;
	cau_out_t           word_c;
	logic [1:0]         cnt_q;
	cau_out_t           e0_q, e1_q;
	logic               push, pop;
	logic               full;

	assign half_re = lane.r_re >= (lane.den - lane.r_re);
	assign half_im = lane.r_im >= (lane.den - lane.r_im);

	always_comb begin
		z0 = lane.cz;
		if (z0 > PI_Z) zc = PI_Z;
		else if (z0 < -PI_Z) zc = -PI_Z;
		else zc = z0;
		zr = 33'(zc) + 33'sd128;
		zsh = zr >>> 8;
		arg_c = lane.a_zero ? 32'd0 : zsh[31:0];
	end

	always_comb begin
		rnd_c.kind    = lane.kind;
		rnd_c.derr    = lane.derr;
		rnd_c.neg_re  = 1'b0;
		rnd_c.neg_im  = 1'b0;
		rnd_c.m_re    = 64'd0;
		rnd_c.m_im    = 64'd0;
		rnd_c.dir_re  = 32'd0;
		rnd_c.dir_im  = 32'd0;
		rnd_c.dir_ovf = 1'b0;
		case (lane.kind)
			OP_ADD, OP_SUB: begin
				rnd_c.dir_re  = lane.as_re;
				rnd_c.dir_im  = lane.as_im;
				rnd_c.dir_ovf = lane.as_ovf;
			end
			OP_MUL: begin
				rnd_c.neg_re = lane.neg_re;
				rnd_c.neg_im = lane.neg_im;
				rnd_c.m_re   = {16'd0, lane.n_re[63:16]} + {63'd0, lane.n_re[15]};
				rnd_c.m_im   = {16'd0, lane.n_im[63:16]} + {63'd0, lane.n_im[15]};
			end
			OP_DIV: begin
				rnd_c.neg_re = lane.neg_re;
				rnd_c.neg_im = lane.neg_im;
				rnd_c.m_re   = {23'd0, lane.q_re} + {63'd0, half_re};
				rnd_c.m_im   = {23'd0, lane.q_im} + {63'd0, half_im};
			end
			OP_MOD: begin
				rnd_c.m_re = lane.sq_res + {63'd0, (lane.sq_n > lane.sq_res)};
			end
			OP_ARG: begin
				rnd_c.dir_re = arg_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_valid_s1 <= 1'b0;
		end else if (adv) begin
			rnd_valid_s1 <= lane_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rnd_s1 <= rnd_c;
		end
	end

	assign sr = sat_sm(rnd_s1.neg_re, rnd_s1.m_re);
	assign si = sat_sm(rnd_s1.neg_im, rnd_s1.m_im);

	always_comb begin
		word_c = '0;
		case (rnd_s1.kind)
			OP_ADD, OP_SUB, OP_ARG: begin
				word_c.res_re   = rnd_s1.dir_re;
				word_c.res_im   = rnd_s1.dir_im;
				word_c.overflow = rnd_s1.dir_ovf;
			end
			OP_MUL, OP_MOD: begin
				word_c.res_re   = sr[31:0];
				word_c.res_im   = si[31:0];
				word_c.overflow = sr[32] | si[32];
			end
			OP_DIV: begin
				if (rnd_s1.derr) begin
					word_c.div_error = 1'b1;
				end else begin
					word_c.res_re   = sr[31:0];
					word_c.res_im   = si[31:0];
					word_c.overflow = sr[32] | si[32];
				end
			end
			default: begin
			end
		endcase
	end

	// output buffer
	assign full      = (cnt_q == SKID_DEPTH);
	assign adv       = !full;
	assign push      = adv && rnd_valid_s1;
	assign res_valid = (cnt_q != 2'd0);
	assign pop       = res_valid && !res_stall;
	assign res       = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && (pop || cnt_q == 2'd0)) begin
			e0_q <= (pop && cnt_q == SKID_DEPTH) ? e1_q : word_c;
		end else if (pop) begin
			e0_q <= e1_q;
		end
		if (push && !pop && cnt_q == 2'd1) begin
			e1_q <= word_c;
		end
	end

	`CAU_CHECK(a_cnt_range, cnt_q != 2'd3, "output buffer count out of range")
	`CAU_CHECK_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "missed a push")
	`CAU_CHECK_NEXT(a_full_hold, full && !pop, full && $stable(e1_q), "full buffer changed")
	`CAU_CHECK(a_derr_div, !rnd_valid_s1 || !rnd_s1.derr || rnd_s1.kind == OP_DIV, "bad derr")

endmodule

// ===== rtl/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply, divide, modulus and argument on signed
// Q16.16 operands, built as a chain of step cells.
// ----------------------------------------------------------------------------
// a result passes the front stages, step cells, rounding register and output buffer
// throughput: one word per cycle, every stage takes a new word each cycle while not stalled
// the whole chain stalls only while the two-word output buffer is full
// reset: asynchronous, clears all valid bits and the output buffer count
module complex_arith_unit
	import cau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     op_valid,
	output logic     op_stall,
	input  cau_in_t  op,
	output logic     res_valid,
	input  logic     res_stall,
	output cau_out_t res
);

	logic      adv;
	logic      lane_valid [0:DIV_STEPS];
	cau_lane_t lane       [0:DIV_STEPS];

	assign op_stall = !adv;

	cau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.op_valid   (op_valid),
		.op         (op),
		.lane_valid (lane_valid[0]),
		.lane       (lane[0])
	);

	for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_cell
		cau_cell #(
			.STEP (gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (lane_valid[gi]),
			.in_lane   (lane[gi]),
			.out_valid (lane_valid[gi + 1]),
			.out_lane  (lane[gi + 1])
		);
	end

	cau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_valid (lane_valid[DIV_STEPS]),
		.lane       (lane[DIV_STEPS]),
		.res_stall  (res_stall),
		.adv        (adv),
		.res_valid  (res_valid),
		.res        (res)
	);

endmodule
